### design/kgs_pkg.sv
// ----------------------------------------------------------------------------
// kgs_pkg: shared types and constants
// Payload structs, register indexes, operation codes and sequencer states for
// the gray-level k-means segmentation unit.
// ----------------------------------------------------------------------------
package kgs_pkg;

	localparam int unsigned MaxPixels   = 65536;
	localparam int unsigned MaxSegments = 16;
	localparam int unsigned PixelBits   = 8;
	localparam int unsigned FracBits    = 8;

	localparam int unsigned AddrBits  = $clog2(MaxPixels);
	localparam int unsigned TotalBits = AddrBits + 1;
	localparam int unsigned LabelBits = $clog2(MaxSegments);
	localparam int unsigned CentBits  = PixelBits + FracBits;
	localparam int unsigned SumBits   = 24;
	localparam int unsigned CountBits = 17;
	localparam int unsigned DivBits   = SumBits + FracBits;

	localparam logic [15:0]         LfsrTaps = 16'hB400;
	localparam logic [CentBits-1:0] HalfStep = 16'd128;

	typedef enum logic [1:0] {
		CFG_SEGMENT_COUNT   = 2'd0,
		CFG_ITERATION_LIMIT = 2'd1,
		CFG_RANDOM_SEED     = 2'd2
	} cfg_index_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  pixel_value;
		logic        last_pixel;
		logic [15:0] read_position;
	} in_item_t;

	typedef struct packed {
		logic [3:0] segment_label;
		logic [7:0] segment_value;
		logic [7:0] passes_used;
		logic       converged;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_ASG_RD,
		ST_ASG_CMP,
		ST_UPD_START,
		ST_UPD_DIV,
		ST_UPD_EVAL,
		ST_UPD_END,
		ST_COPY,
		ST_RD_ADDR,
		ST_RD_OUT
	} state_t;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### design/kgs_divider.sv
// ----------------------------------------------------------------------------
// kgs_divider: iterative restoring divider
// Produces one quotient bit per cycle; the result is the truncated quotient.
// ----------------------------------------------------------------------------
module kgs_divider import kgs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DivBits-1:0]    dividend,
	input  logic [CountBits-1:0]  divisor,
	output div_status_t           status,
	output logic [CentBits-1:0]   quotient
);

	localparam int unsigned CntBits = $clog2(DivBits + 1);

	logic [CountBits-1:0] rem_q;
	logic [DivBits-1:0]   quo_q;
	logic [CountBits-1:0] div_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CountBits:0]   trial;
	logic [CountBits:0]   diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, quo_q[DivBits-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(DivBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CountBits-1:0] : trial[CountBits-1:0];
			quo_q <= {quo_q[DivBits-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q[CentBits-1:0];

endmodule

### design/kmeans_gray_segmentation_unit.sv
// ----------------------------------------------------------------------------
// kmeans_gray_segmentation_unit: one-dimensional k-means on a gray image
// Loads 8-bit pixels, clusters them after the last one and answers reads with
// each pixel's label, its rounded centroid, the passes used and convergence.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in      | input     | in_valid/in_stall  | in_data (in_item_t)
//  out     | output    | out_valid/out_stall| out_data (out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A read passes through the transfer, the label memory read, then the centroid lookup into
// the output register. A load flagged last starts clustering: seeding walks all sixteen
// centroid slots, then each pass reads each pixel and compares it once per centroid,
// updates each nonempty cluster with the serial divider and reseeds each empty one,
// closes the pass and copies the centroids when a centroid moved.
// Reset clears all control state; the pixel and label memories hold nothing until written.
// A stalled output holds the sequencer only in the last read cycle.
module kmeans_gray_segmentation_unit import kgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [4:0]  seg_count_q;
	logic [7:0]  iter_limit_q;
	logic [15:0] seed_q;

	// Image state.
	logic [PixelBits-1:0] pixel_mem [MaxPixels];
	logic [LabelBits-1:0] label_mem [MaxPixels];
	logic [TotalBits-1:0] total_q;
	logic                 closed_q;
	logic                 results_valid_q;

	// Clustering state.
	logic [CentBits-1:0]  cent_q  [MaxSegments];
	logic [CentBits-1:0]  fresh_q [MaxSegments];
	logic [SumBits-1:0]   sum_q   [MaxSegments];
	logic [CountBits-1:0] count_q [MaxSegments];
	logic [15:0]          lfsr_q;
	logic [7:0]           pass_q;
	logic                 converged_q;
	logic                 moved_q;
	logic [LabelBits-1:0] c_q;
	logic [AddrBits-1:0]  i_q;
	logic [LabelBits-1:0] best_q;
	logic [CentBits-1:0]  best_d_q;
	logic [CentBits-1:0]  fresh_val_q;

	// Read path.
	logic [15:0]          pos_q;
	logic                 pos_ok_q;
	logic [PixelBits-1:0] pix_rd_q;
	logic [LabelBits-1:0] lbl_rd_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	state_t state_q, state_n;

	// Derived values and the shared compare unit.
	logic [4:0]           k_eff;
	logic [LabelBits-1:0] k_last;
	logic [7:0]           limit_eff;
	logic [15:0]          seed_eff;
	logic [15:0]          lfsr_next;
	logic                 in_acc;
	logic [TotalBits-1:0] load_base;
	logic [LabelBits-1:0] cidx;
	logic [CentBits-1:0]  cent_rd;
	logic [CentBits-1:0]  pix_q88;
	logic [CentBits-1:0]  pix_dist;
	logic                 take;
	logic [LabelBits-1:0] best_n;
	logic [CentBits-1:0]  best_dn;
	logic [CentBits-1:0]  move_d;
	logic                 c_is_last;
	logic                 i_is_last;
	logic [CentBits:0]    rounded;
	logic [7:0]           seg_value;
	logic                 div_start;
	div_status_t          div_st;
	logic [CentBits-1:0]  div_quot;

	always_comb begin
		if (seg_count_q == 5'd0) begin
			k_eff = 5'd1;
		end else if (seg_count_q > 5'(MaxSegments)) begin
			k_eff = 5'(MaxSegments);
		end else begin
			k_eff = seg_count_q;
		end
		k_last    = LabelBits'(k_eff - 5'd1);
		limit_eff = (iter_limit_q == 8'd0) ? 8'd1 : iter_limit_q;
		seed_eff  = (seed_q == 16'd0) ? 16'd1 : seed_q;
		lfsr_next = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LfsrTaps : 16'd0);
	end

	assign in_acc    = in_valid && !in_stall;
	assign load_base = closed_q ? '0 : total_q;
	assign c_is_last = (c_q == k_last);
	assign i_is_last = ({1'b0, i_q} == (total_q - 1'b1));

	// One centroid read port, shared by the assign, update and read phases.
	assign cidx    = (state_q == ST_RD_OUT) ? lbl_rd_q : c_q;
	assign cent_rd = cent_q[cidx];

	always_comb begin
		pix_q88  = {pix_rd_q, FracBits'(0)};
		pix_dist = (pix_q88 > cent_rd) ? (pix_q88 - cent_rd) : (cent_rd - pix_q88);
		take     = (c_q == '0) || (pix_dist < best_d_q);
		best_n   = take ? c_q : best_q;
		best_dn  = take ? pix_dist : best_d_q;
		move_d   = (fresh_val_q > cent_rd) ? (fresh_val_q - cent_rd)
		                                   : (cent_rd - fresh_val_q);
		rounded = {1'b0, cent_rd} + {1'b0, HalfStep};
		seg_value = (rounded[CentBits:FracBits] > 9'd255) ? 8'd255
		                                                  : rounded[FracBits+7:FracBits];
	end

	kgs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_q[c_q], FracBits'(0)}),
		.divisor  (count_q[c_q]),
		.status   (div_st),
		.quotient (div_quot)
	);

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_data.op == OP_READ) begin
						state_n = ST_RD_ADDR;
					end else if (in_data.last_pixel) begin
						state_n = ST_SEED;
					end
				end
			end
			ST_SEED: begin
				if (c_q == LabelBits'(MaxSegments - 1)) begin
					state_n = ST_ASG_RD;
				end
			end
			ST_ASG_RD: state_n = ST_ASG_CMP;
			ST_ASG_CMP: begin
				if (c_is_last) begin
					state_n = i_is_last ? ST_UPD_START : ST_ASG_RD;
				end
			end
			ST_UPD_START: begin
				state_n = (count_q[c_q] != '0) ? ST_UPD_DIV : ST_UPD_EVAL;
			end
			ST_UPD_DIV: begin
				if (div_st.done) begin
					state_n = ST_UPD_EVAL;
				end
			end
			ST_UPD_EVAL: state_n = c_is_last ? ST_UPD_END : ST_UPD_START;
			ST_UPD_END:  state_n = moved_q ? ST_COPY : ST_IDLE;
			ST_COPY: begin
				if (c_is_last) begin
					state_n = (pass_q == limit_eff) ? ST_IDLE : ST_ASG_RD;
				end
			end
			ST_RD_ADDR: state_n = ST_RD_OUT;
			ST_RD_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		cfg_ready = 1'b1;
		div_start = (state_q == ST_UPD_START) && (count_q[c_q] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q  <= 5'd4;
			iter_limit_q <= 8'd100;
			seed_q       <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEGMENT_COUNT:   seg_count_q  <= cfg_data[4:0];
				CFG_ITERATION_LIMIT: iter_limit_q <= cfg_data[7:0];
				CFG_RANDOM_SEED:     seed_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories: registered reads; pixel writes by loads, label writes by the sequencer.
	always_ff @(posedge clk) begin
		pix_rd_q <= pixel_mem[i_q];
		if (in_acc && (in_data.op == OP_LOAD) && (load_base < TotalBits'(MaxPixels))) begin
			pixel_mem[load_base[AddrBits-1:0]] <= in_data.pixel_value;
		end
	end

	always_ff @(posedge clk) begin
		lbl_rd_q <= label_mem[pos_q[AddrBits-1:0]];
		if ((state_q == ST_ASG_CMP) && c_is_last) begin
			label_mem[i_q] <= best_n;
		end
	end

	// Control and status registers of the image and the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q         <= '0;
			closed_q        <= 1'b0;
			results_valid_q <= 1'b0;
			pass_q          <= '0;
			converged_q     <= 1'b0;
			moved_q         <= 1'b0;
			c_q             <= '0;
			i_q             <= '0;
			lfsr_q          <= 16'd1;
			out_valid_q     <= 1'b0;
		end else begin
			// The result register fills in the last read cycle and empties on a transfer.
			if ((state_q == ST_RD_OUT) && !(out_valid_q && out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_data.op == OP_LOAD)) begin
						if (closed_q) begin
							closed_q        <= 1'b0;
							results_valid_q <= 1'b0;
						end
						if (load_base < TotalBits'(MaxPixels)) begin
							total_q <= load_base + 1'b1;
						end else begin
							total_q <= load_base;
						end
						if (in_data.last_pixel) begin
							lfsr_q      <= seed_eff;
							c_q         <= '0;
							pass_q      <= '0;
							converged_q <= 1'b0;
						end
					end
				end
				ST_SEED: begin
					if ({1'b0, c_q} < k_eff) begin
						lfsr_q <= lfsr_next;
					end
					c_q     <= c_q + 1'b1;
					i_q     <= '0;
					moved_q <= 1'b0;
				end
				ST_ASG_RD: c_q <= '0;
				ST_ASG_CMP: begin
					if (c_is_last) begin
						c_q <= '0;
						if (!i_is_last) begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_UPD_START: begin
					if (count_q[c_q] == '0) begin
						lfsr_q <= lfsr_next;
					end
				end
				ST_UPD_DIV: ;
				ST_UPD_EVAL: begin
					if (move_d >= HalfStep) begin
						moved_q <= 1'b1;
					end
					c_q <= c_is_last ? '0 : c_q + 1'b1;
				end
				ST_UPD_END: begin
					pass_q <= pass_q + 1'b1;
					if (!moved_q) begin
						converged_q     <= 1'b1;
						closed_q        <= 1'b1;
						results_valid_q <= 1'b1;
					end
				end
				ST_COPY: begin
					if (c_is_last) begin
						c_q     <= '0;
						i_q     <= '0;
						moved_q <= 1'b0;
						if (pass_q == limit_eff) begin
							closed_q        <= 1'b1;
							results_valid_q <= 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_RD_ADDR: ;
				ST_RD_OUT: ;
				default: ;
			endcase
		end
	end

	// Payload registers: tables, compare state and the output item.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_data.op == OP_READ)) begin
					pos_q    <= in_data.read_position;
					pos_ok_q <= results_valid_q && ({1'b0, in_data.read_position} < total_q);
				end
			end
			ST_SEED: begin
				if ({1'b0, c_q} < k_eff) begin
					cent_q[c_q] <= {lfsr_next[7:0], FracBits'(0)};
				end
				sum_q[c_q]   <= '0;
				count_q[c_q] <= '0;
			end
			ST_ASG_CMP: begin
				best_q   <= best_n;
				best_d_q <= best_dn;
				if (c_is_last) begin
					sum_q[best_n]   <= sum_q[best_n] + SumBits'(pix_rd_q);
					count_q[best_n] <= count_q[best_n] + 1'b1;
				end
			end
			ST_UPD_START: begin
				if (count_q[c_q] == '0) begin
					fresh_val_q <= {lfsr_next[7:0], FracBits'(0)};
				end
			end
			ST_UPD_DIV: begin
				if (div_st.done) begin
					fresh_val_q <= div_quot;
				end
			end
			ST_UPD_EVAL: begin
				fresh_q[c_q] <= fresh_val_q;
				sum_q[c_q]   <= '0;
				count_q[c_q] <= '0;
			end
			ST_COPY: cent_q[c_q] <= fresh_q[c_q];
			ST_RD_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					if (pos_ok_q) begin
						out_q.segment_label <= lbl_rd_q;
						out_q.segment_value <= seg_value;
						out_q.passes_used   <= pass_q;
						out_q.converged     <= converged_q;
					end else begin
						out_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// The divider is only started for a cluster that holds pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (count_q[c_q] != '0))
		else $error("divider started on an empty cluster");

	// A committed label always names one of the active clusters.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ASG_CMP) && c_is_last) |-> ({1'b0, best_n} < k_eff))
		else $error("label outside the active clusters");

	// The divider is never restarted while a division is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> !div_start)
		else $error("divider restarted while busy");

	// The pixel count never passes the image capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TotalBits'(MaxPixels))
		else $error("pixel count beyond capacity");
`endif

endmodule
